// File: src/ttuv_pkg.sv
// ----------------------------------------------------------------------------
// ttuv_pkg - shared types and constants for the triangle tangent block
// Widths of the fixed-point corner data, edge deltas, wide products and
// the saturation limits of the Q16.16 tangent.
// ----------------------------------------------------------------------------
package ttuv_pkg;

  localparam int IDX_W   = 16;              // vertex index
  localparam int COORD_W = 32;              // Q16.16 coordinate
  localparam int DELTA_W = COORD_W + 1;     // exact difference of two coordinates
  localparam int PROD_W  = 2 * DELTA_W;     // exact product of two deltas
  localparam int WIDE_W  = PROD_W + 1;      // difference of two products
  localparam int QUO_W   = 32;              // tangent component
  localparam int FRAC_W  = 16;              // fraction bits, 1.0 = 2^FRAC_W

  localparam int IN_DATA_W  = IDX_W + 5 * COORD_W;
  localparam int OUT_DATA_W = 3 * QUO_W + 3 * IDX_W;

  localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic [QUO_W-1:0]          quo_t;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: src/ttuv_mul.sv
// ----------------------------------------------------------------------------
// ttuv_mul - shared signed delta multiplier
// Multiplies two exact 33-bit deltas and registers the 66-bit product.
// ----------------------------------------------------------------------------
module ttuv_mul import ttuv_pkg::*; (
  input  logic   clk,
  input  delta_t a,
  input  delta_t b,
  output prod_t  prod
);

  prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// File: src/ttuv_div.sv
// ----------------------------------------------------------------------------
// ttuv_div - iterative signed divider for the tangent components
// Computes trunc(num * 2^16 / den) saturated to 32 bits, one quotient bit
// per cycle through a single wide subtractor, after an overflow check.
// ----------------------------------------------------------------------------
module ttuv_div import ttuv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  input  wide_t    num,
  input  wide_t    den,
  output div_sts_t sts,
  output quo_t     quo
);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_ITER  = 2'd2;
  localparam logic [1:0] D_FIN   = 2'd3;

  localparam int REM_W = WIDE_W;      // remainder stays below the divisor
  localparam int CND_W = REM_W + 1;   // remainder shifted by one bit
  localparam int CNT_W = $clog2(QUO_W);

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  logic [WIDE_W-1:0] nmag_r, dmag_r;
  logic              neg_r, ovf_r;
  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  sh_r;
  quo_t              q_r, quo_r;

  logic [CND_W-1:0]  cand;
  logic [CND_W:0]    diff;
  logic              borrow;
  logic [WIDE_W-1:0] num_mag, den_mag;

  assign num_mag = num[WIDE_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[WIDE_W-1] ? (~den + 1'b1) : den;

  // shared subtractor: check stage compares the high dividend part
  always_comb begin
    if (state_r == D_CHECK) begin
      cand = {{(FRAC_W+1){1'b0}}, nmag_r[WIDE_W-1:FRAC_W]};
    end else begin
      cand = {rem_r, sh_r[QUO_W-1]};
    end
  end

  assign diff   = {1'b0, cand} - {2'b00, dmag_r};
  assign borrow = diff[CND_W];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          state_nxt = D_CHECK;
        end
      end
      D_CHECK: begin
        cnt_nxt = '0;
        if (!borrow) begin
          state_nxt = D_FIN;
        end else begin
          state_nxt = D_ITER;
        end
      end
      D_ITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          nmag_r <= num_mag;
          dmag_r <= den_mag;
          neg_r  <= num[WIDE_W-1] ^ den[WIDE_W-1];
        end
      end
      D_CHECK: begin
        ovf_r <= !borrow;
        rem_r <= cand[REM_W-1:0];
        sh_r  <= {nmag_r[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
        q_r   <= '0;
      end
      D_ITER: begin
        rem_r <= borrow ? cand[REM_W-1:0] : diff[REM_W-1:0];
        sh_r  <= {sh_r[QUO_W-2:0], 1'b0};
        q_r   <= {q_r[QUO_W-2:0], !borrow};
      end
      D_FIN: begin
        // apply sign and clamp to the signed range
        if (neg_r) begin
          quo_r <= (ovf_r || (q_r > SAT_NEG)) ? SAT_NEG : (~q_r + 1'b1);
        end else begin
          quo_r <= (ovf_r || q_r[QUO_W-1]) ? SAT_POS : q_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.busy = (state_r != D_IDLE);
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

// File: src/triangle_tangent_from_uv.sv
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv - per-triangle tangent from UV deltas
// Collects three corners, forms edge and UV deltas, builds the UV
// determinant and three numerators on a shared multiplier, and divides
// each numerator by the determinant on a shared iterative divider.
//
//   channel | dir | tdata (low bit up)                         | tuser
//   --------+-----+--------------------------------------------+-----------
//   in_     | in  | vertex_index, pos_x, pos_y, pos_z, tex_u,  | -
//           |     | tex_v                                      |
//   out_    | out | tangent_x, tangent_y, tangent_z,           | degenerate
//           |     | corner_a_index, corner_b_index,            |
//           |     | corner_c_index                             |
//
// Corners A and B do not lower in_tready. Corner C holds it low through
// the multiplier pairs, check, three divisions (one quotient bit per
// cycle, none on overflow), output load; no divisions when degenerate.
// Reset clears the corner phase and the output valid; held corners need none.
// A stalled result waits in the output register; corners A and B of the next
// triangle are still taken meanwhile, corner C stalls at its end.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv import ttuv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tangent_x, tangent_y, tangent_z, corner_a_index, corner_b_index,
  // corner_c_index
  output logic [OUT_DATA_W-1:0] out_tdata,
  // degenerate
  output logic                  out_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DST  = 3'd3;
  localparam logic [2:0] S_DWT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  localparam int NPAIR = 8;               // determinant plus three numerators
  localparam int MCNT_W = $clog2(NPAIR + 1);

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic [1:0]        kidx_r, kidx_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  coord_t pa_r [3];
  coord_t pb_r [3];
  coord_t ta_r [2];
  coord_t tb_r [2];
  idx_t   ia_r, ib_r, ic_r;

  delta_t e1_r [3];
  delta_t e2_r [3];
  delta_t d1u_r, d1v_r, d2u_r, d2v_r;

  wide_t  acc_r;
  wide_t  res_r [4];   // determinant, then the three numerators
  quo_t   tan_r [3];
  logic   deg_r;

  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  idx_t   in_idx;
  coord_t in_pos [3];
  coord_t in_tex [2];

  delta_t   mul_a, mul_b;
  prod_t    prod;
  wide_t    prod_ext;
  logic [MCNT_W-1:0] pidx;
  div_req_t div_req;
  div_sts_t div_sts;
  quo_t     div_quo;
  logic [1:0] num_sel;
  logic     in_acc, out_load;

  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_pos[0] = in_tdata[IDX_W + 0*COORD_W +: COORD_W];
  assign in_pos[1] = in_tdata[IDX_W + 1*COORD_W +: COORD_W];
  assign in_pos[2] = in_tdata[IDX_W + 2*COORD_W +: COORD_W];
  assign in_tex[0] = in_tdata[IDX_W + 3*COORD_W +: COORD_W];
  assign in_tex[1] = in_tdata[IDX_W + 4*COORD_W +: COORD_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // operand pairs: d1u*d2v, d2u*d1v, then d2v*e1[k], d1v*e2[k] per axis
  always_comb begin
    case (mcnt_r)
      4'd0:    begin mul_a = d1u_r; mul_b = d2v_r;    end
      4'd1:    begin mul_a = d2u_r; mul_b = d1v_r;    end
      4'd2:    begin mul_a = d2v_r; mul_b = e1_r[0];  end
      4'd3:    begin mul_a = d1v_r; mul_b = e2_r[0];  end
      4'd4:    begin mul_a = d2v_r; mul_b = e1_r[1];  end
      4'd5:    begin mul_a = d1v_r; mul_b = e2_r[1];  end
      4'd6:    begin mul_a = d2v_r; mul_b = e1_r[2];  end
      default: begin mul_a = d1v_r; mul_b = e2_r[2];  end
    endcase
  end

  ttuv_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_ext = {prod[PROD_W-1], prod};
  assign pidx     = mcnt_r - 1'b1;
  assign num_sel  = kidx_r + 2'd1;

  assign div_req.start = (state_r == S_DST);

  ttuv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (res_r[num_sel]),
    .den   (res_r[0]),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    mcnt_nxt       = mcnt_r;
    kidx_nxt       = kidx_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            PH_B:    phase_nxt = PH_C;
            PH_C: begin
              phase_nxt = PH_A;
              mcnt_nxt  = '0;
              state_nxt = S_MUL;
            end
            default: phase_nxt = PH_B;
          endcase
        end
      end
      S_MUL: begin
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == MCNT_W'(NPAIR)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        kidx_nxt = '0;
        if (res_r[0] == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DST;
        end
      end
      S_DST: begin
        state_nxt = S_DWT;
      end
      S_DWT: begin
        if (div_sts.done) begin
          kidx_nxt = kidx_r + 1'b1;
          if (kidx_r == 2'd2) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DST;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_A;
      mcnt_r       <= '0;
      kidx_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      mcnt_r       <= mcnt_nxt;
      kidx_r       <= kidx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // corner capture and exact deltas on corner C
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (phase_r)
        PH_B: begin
          for (int k = 0; k < 3; k++) pb_r[k] <= in_pos[k];
          tb_r[0] <= in_tex[0];
          tb_r[1] <= in_tex[1];
          ib_r    <= in_idx;
        end
        PH_C: begin
          for (int k = 0; k < 3; k++) begin
            e1_r[k] <= {pb_r[k][COORD_W-1], pb_r[k]} - {pa_r[k][COORD_W-1], pa_r[k]};
            e2_r[k] <= {in_pos[k][COORD_W-1], in_pos[k]} - {pa_r[k][COORD_W-1], pa_r[k]};
          end
          d1u_r <= {tb_r[0][COORD_W-1], tb_r[0]} - {ta_r[0][COORD_W-1], ta_r[0]};
          d1v_r <= {tb_r[1][COORD_W-1], tb_r[1]} - {ta_r[1][COORD_W-1], ta_r[1]};
          d2u_r <= {in_tex[0][COORD_W-1], in_tex[0]} - {ta_r[0][COORD_W-1], ta_r[0]};
          d2v_r <= {in_tex[1][COORD_W-1], in_tex[1]} - {ta_r[1][COORD_W-1], ta_r[1]};
          ic_r  <= in_idx;
        end
        default: begin
          for (int k = 0; k < 3; k++) pa_r[k] <= in_pos[k];
          ta_r[0] <= in_tex[0];
          ta_r[1] <= in_tex[1];
          ia_r    <= in_idx;
        end
      endcase
    end
  end

  // accumulate product pairs: even product loads, odd product subtracts
  always_ff @(posedge clk) begin
    if ((state_r == S_MUL) && (mcnt_r != '0)) begin
      if (!pidx[0]) begin
        acc_r <= prod_ext;
      end else begin
        res_r[pidx[2:1]] <= acc_r - prod_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHK) begin
      deg_r <= (res_r[0] == '0);
      for (int k = 0; k < 3; k++) tan_r[k] <= '0;
    end else if ((state_r == S_DWT) && div_sts.done) begin
      tan_r[kidx_r] <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {ic_r, ib_r, ia_r, tan_r[2], tan_r[1], tan_r[0]};
      out_tuser_r <= deg_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: src/ttuv_check.sv
// ----------------------------------------------------------------------------
// ttuv_check - port-level checks for the triangle tangent block
// Watches the result channel over time and binds to the top level.
// ----------------------------------------------------------------------------
module ttuv_check import ttuv_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // degenerate triangle carries a zero tangent
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3*QUO_W-1:0] == '0)
    else $error("degenerate result with nonzero tangent");

  // a new result frees the input side in the same cycle
  a_rose_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while corner C still in work");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind triangle_tangent_from_uv ttuv_check u_ttuv_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
